// ----- rtl/cuckoo_hash_map_assert.svh -----
// ----------------------------------------------------------------------------
// Cuckoo hash map assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef CUCKOO_HASH_MAP_ASSERT_SVH
`define CUCKOO_HASH_MAP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CKH_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cuckoo_hash_map: same-cycle check failed");

// next-cycle implication, disabled during reset
`define CKH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cuckoo_hash_map: next-cycle check failed");

`endif

// ----- rtl/ckh_pkg.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash map package
// Sizes, codes, payload types and the digit reduction step of the hash.
// ----------------------------------------------------------------------------
package ckh_pkg;

  localparam int TABLE_ENTRIES = 4096;
  localparam int MAX_KICKS     = 256;
  localparam int STORE_DEPTH   = 2 * TABLE_ENTRIES;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int KICK_W        = $clog2(MAX_KICKS + 2);
  localparam int KEY_W         = 63;
  localparam int VAL_W         = 32;
  localparam int MULT_W        = 64;
  localparam int ENTRY_W       = KEY_W + VAL_W;

  localparam logic [SLOT_W-1:0] MOD_ONE = SLOT_W'(TABLE_ENTRIES - 5);
  localparam logic [SLOT_W-1:0] MOD_TWO = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [KEY_W-1:0]  EMPTY_KEY = '1;

  localparam logic [MULT_W-1:0] MULT_ONE_RST = 64'd392746233656539461;
  localparam logic [MULT_W-1:0] MULT_TWO_RST = 64'd318372663882574251;

  localparam logic [31:0] RND_X_RST = 32'd123456789;
  localparam logic [31:0] RND_Y_RST = 32'd362436069;
  localparam logic [31:0] RND_Z_RST = 32'd521288629;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  localparam logic CFG_MULT_ONE = 1'b0;
  localparam logic CFG_MULT_TWO = 1'b1;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ckh_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
  } ckh_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ckh_entry_t;

  // fold one 4-bit digit into a remainder: (rem*16 + digit) mod modulus
  function automatic logic [SLOT_W-1:0] reduce_digit(
    input logic [SLOT_W-1:0] rem,
    input logic [3:0]        digit,
    input logic [SLOT_W-1:0] modulus
  );
    logic [SLOT_W+3:0] t;
    logic [SLOT_W+3:0] m;
    t = {rem, digit};
    for (int j = 3; j >= 0; j--) begin
      m = {4'b0, modulus} << j;
      if (t >= m) begin
        t = t - m;
      end
    end
    return t[SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/ckh_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ckh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ckh_hash_lane.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash lane
// Low 64 bits of key*mult from three 32x32 products, then the remainder by
// the table modulus, one 4-bit digit per cycle.
// ----------------------------------------------------------------------------
module ckh_hash_lane
  import ckh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [MULT_W-1:0] mult,
  input  logic [SLOT_W-1:0] modulus,
  output logic              done,
  output logic [SLOT_W-1:0] slot
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_RED  = 2'd2;

  logic [1:0]        phase_r, phase_nxt;
  logic [1:0]        step_r, step_nxt;
  logic [3:0]        dig_r, dig_nxt;
  logic              done_r, done_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [31:0]       op_a, op_b;
  logic [63:0]       product;

  // pick the partial product for this step
  always_comb begin
    case (step_r)
      2'd0: begin
        op_a = key[31:0];
        op_b = mult[31:0];
      end
      2'd1: begin
        op_a = key[31:0];
        op_b = mult[63:32];
      end
      default: begin
        op_a = {1'b0, key[62:32]};
        op_b = mult[31:0];
      end
    endcase
  end

  assign product = op_a * op_b;

  // sequence multiply, accumulate and digit reduction
  always_comb begin
    phase_nxt = phase_r;
    step_nxt  = step_r;
    dig_nxt   = dig_r;
    done_nxt  = 1'b0;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_MUL;
          step_nxt  = 2'd0;
        end
      end
      PH_MUL: begin
        prod_nxt = product;
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: acc_nxt = acc_r;
          2'd1: acc_nxt = prod_r;
          default: acc_nxt = acc_r + {prod_r[31:0], 32'b0};
        endcase
        if (step_r == 2'd3) begin
          phase_nxt = PH_RED;
          dig_nxt   = 4'd0;
          rem_nxt   = '0;
        end
      end
      PH_RED: begin
        rem_nxt = reduce_digit(rem_r, acc_r[63:60], modulus);
        acc_nxt = acc_r << 4;
        dig_nxt = dig_r + 4'd1;
        if (dig_r == 4'd15) begin
          phase_nxt = PH_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dig_r  <= dig_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign slot = rem_r;

endmodule

// ----- rtl/ckh_rng.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash random source
// xorshf96 generator; shows bit 0 of the word the next advance produces.
// ----------------------------------------------------------------------------
module ckh_rng
  import ckh_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  output logic rnd_bit
);

  logic [31:0] x_r, y_r, z_r;
  logic [31:0] s1, s2, s3, t_new;

  // next output word
  always_comb begin
    s1    = x_r ^ (x_r << 16);
    s2    = s1 ^ (s1 >> 5);
    s3    = s2 ^ (s2 << 1);
    t_new = s3 ^ y_r ^ z_r;
  end

  assign rnd_bit = t_new[0];

  // rotate the words on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= RND_X_RST;
      y_r <= RND_Y_RST;
      z_r <= RND_Z_RST;
    end else if (adv) begin
      x_r <= y_r;
      y_r <= z_r;
      z_r <= t_new;
    end
  end

endmodule

// ----- rtl/cuckoo_hash_map.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash map
// Two-table cuckoo map of 63-bit keys to 32-bit values in one entry RAM.
// ----------------------------------------------------------------------------
// One item is worked at a time. Each hash is three shared-lane 32x32 products,
// then sixteen 4-bit modulo digits, both tables in parallel, followed by the
// two slot reads; insert repeats hash and reads for each displacement, up to
// MAX_KICKS+1 displacements. The clear operation and reset both sweep all
// 2*TABLE_ENTRIES (8192) entries of the entry RAM one entry per cycle, with
// in_ready low; configuration writes are taken at all times. A finished result
// waits in the output register while the next item is taken.
module cuckoo_hash_map
  import ckh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ckh_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ckh_out_t          out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [MULT_W-1:0] cfg_data
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_RDA    = 3'd3;
  localparam logic [2:0] S_RDB    = 3'd4;
  localparam logic [2:0] S_EVAL   = 3'd5;
  localparam logic [2:0] S_REMB   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_reply_r, clr_reply_nxt;
  logic              out_valid_r, out_valid_nxt;
  ckh_out_t          out_data_r, out_data_nxt;
  logic [MULT_W-1:0] mult_one_r, mult_two_r;

  logic [1:0]        op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [KICK_W-1:0] kicks_r, kicks_nxt;
  logic [ADDR_W-1:0] slot_a_r, slot_a_nxt;
  logic [ADDR_W-1:0] slot_b_r, slot_b_nxt;
  ckh_entry_t        ent_a_r, ent_a_nxt;
  ckh_out_t          res_r, res_nxt;

  logic              hash_start;
  logic              done_one, done_two;
  logic [SLOT_W-1:0] slot_one, slot_two;
  logic              rnd_adv, rnd_bit;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  ckh_entry_t        mem_wdata, mem_rdata, victim;
  logic              in_xfer, out_load;

  assign in_xfer = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // hash lanes, one per table
  ckh_hash_lane u_lane_one (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key     (key_r),
    .mult    (mult_one_r),
    .modulus (MOD_ONE),
    .done    (done_one),
    .slot    (slot_one)
  );

  ckh_hash_lane u_lane_two (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (hash_start),
    .key     (key_r),
    .mult    (mult_two_r),
    .modulus (MOD_TWO),
    .done    (done_two),
    .slot    (slot_two)
  );

  ckh_rng u_rng (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (rnd_adv),
    .rnd_bit (rnd_bit)
  );

  ckh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // read slot one first, then slot two; data lands in the following cycle
  assign mem_raddr = (state_r == S_RDA) ? slot_a_r : slot_b_r;
  assign victim    = rnd_bit ? mem_rdata : ent_a_r;

  // main sequencer; every write is followed by a full rehash before the next
  // read, so reads never overlap a write to the same entry
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    kicks_nxt     = kicks_r;
    slot_a_nxt    = slot_a_r;
    slot_b_nxt    = slot_b_r;
    ent_a_nxt     = ent_a_r;
    res_nxt       = res_r;
    hash_start    = 1'b0;
    rnd_adv       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_a_r;
    mem_wdata     = '{key: key_r, value: val_r};
    out_load      = 1'b0;
    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '{key: EMPTY_KEY, value: '0};
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(STORE_DEPTH - 1)) begin
          state_nxt     = clr_reply_r ? S_FINISH : S_IDLE;
          clr_reply_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt    = in_data.operation;
          key_nxt   = in_data.key;
          val_nxt   = in_data.value;
          kicks_nxt = '0;
          res_nxt   = '{status: ST_OK, found_value: '0};
          if (in_data.operation == OP_CLEAR) begin
            clr_cnt_nxt   = '0;
            clr_reply_nxt = 1'b1;
            state_nxt     = S_CLEAR;
          end else if (in_data.key == EMPTY_KEY) begin
            if (in_data.operation == OP_LOOKUP) begin
              res_nxt.status = ST_MISS;
            end
            state_nxt = S_FINISH;
          end else begin
            hash_start = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (done_one && done_two) begin
          slot_a_nxt = ADDR_W'(slot_one);
          slot_b_nxt = ADDR_W'(slot_two) + ADDR_W'(TABLE_ENTRIES);
          state_nxt  = S_RDA;
        end
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        ent_a_nxt = mem_rdata;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_FINISH;
        case (op_r)
          OP_LOOKUP: begin
            if (ent_a_r.key == key_r) begin
              res_nxt.found_value = ent_a_r.value;
            end else if (mem_rdata.key == key_r) begin
              res_nxt.found_value = mem_rdata.value;
            end else begin
              res_nxt.status = ST_MISS;
            end
          end
          OP_REMOVE: begin
            mem_waddr = slot_a_r;
            mem_wdata = '{key: EMPTY_KEY, value: '0};
            mem_we    = (ent_a_r.key == key_r);
            if (mem_rdata.key == key_r) begin
              state_nxt = S_REMB;
            end
          end
          OP_INSERT: begin
            mem_we = 1'b1;
            if (ent_a_r.key == EMPTY_KEY) begin
              mem_waddr = slot_a_r;
            end else if (mem_rdata.key == EMPTY_KEY) begin
              mem_waddr = slot_b_r;
            end else begin
              // displace the chosen entry and carry it on
              rnd_adv   = 1'b1;
              mem_waddr = rnd_bit ? slot_b_r : slot_a_r;
              key_nxt   = victim.key;
              val_nxt   = victim.value;
              kicks_nxt = kicks_r + KICK_W'(1);
              if (kicks_r == KICK_W'(MAX_KICKS)) begin
                res_nxt.status = ST_FAIL;
              end else begin
                hash_start = 1'b1;
                state_nxt  = S_HASH;
              end
            end
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_REMB: begin
        mem_we    = 1'b1;
        mem_waddr = slot_b_r;
        mem_wdata = '{key: EMPTY_KEY, value: '0};
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_one_r <= MULT_ONE_RST;
      mult_two_r <= MULT_TWO_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MULT_ONE) begin
        mult_one_r <= cfg_data;
      end
      if (cfg_index == CFG_MULT_TWO) begin
        mult_two_r <= cfg_data;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    kicks_r    <= kicks_nxt;
    slot_a_r   <= slot_a_nxt;
    slot_b_r   <= slot_b_nxt;
    ent_a_r    <= ent_a_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/ckh_checker.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash map checker
// Port-level checks over time, bound to the top level.
// ----------------------------------------------------------------------------
`include "cuckoo_hash_map_assert.svh"

module ckh_checker
  import ckh_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ckh_out_t          out_data
);

  // stalled result holds
  `CKH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // only a found lookup carries a value
  `CKH_ASSERT_NOW(a_value_zero, out_valid && out_data.status != ST_OK, out_data.found_value == '0)

  // one item at a time: busy right after a transfer
  `CKH_ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)

  // clearing pass follows reset
  `CKH_ASSERT_NOW(a_clear_after_reset, !$past(rst_n), !in_ready && !out_valid)

endmodule

bind cuckoo_hash_map ckh_checker u_ckh_checker (.*);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// Cuckoo hash map testbench
// Drives lookups, inserts, removes and clears through the valid/ready channels,
// predicts every answer with a software copy of both tables and the xorshift
// generator, and checks each result transfer in order. Idling on both sides
// and a long receiver hold-off exercise the handshakes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ckh_pkg::*;

  // Software copy of the map; predicts the answer of each accepted request
  class map_scoreboard;
    logic [KEY_W-1:0]  keys [STORE_DEPTH];
    logic [VAL_W-1:0]  vals [STORE_DEPTH];
    logic [31:0]       rnd [3];
    logic [MULT_W-1:0] mult_one;
    logic [MULT_W-1:0] mult_two;
    ckh_out_t          pending [$];
    int                errors;

    function new();
      errors = 0;
      mult_one = MULT_ONE_RST;
      mult_two = MULT_TWO_RST;
      rnd[0] = RND_X_RST;
      rnd[1] = RND_Y_RST;
      rnd[2] = RND_Z_RST;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        keys[i] = EMPTY_KEY;
        vals[i] = '0;
      end
    endfunction

    function logic [31:0] next_random();
      logic [31:0] x;
      x = rnd[0];
      x = x ^ (x << 16);
      x = x ^ (x >> 5);
      x = x ^ (x << 1);
      rnd[0] = rnd[1];
      rnd[1] = rnd[2];
      rnd[2] = x ^ rnd[0] ^ rnd[1];
      return rnd[2];
    endfunction

    function int slot_a(logic [KEY_W-1:0] k);
      logic [63:0] p;
      p = {1'b0, k} * mult_one;
      return int'(p % 64'(TABLE_ENTRIES - 5));
    endfunction

    function int slot_b(logic [KEY_W-1:0] k);
      logic [63:0] p;
      p = {1'b0, k} * mult_two;
      return int'(p % 64'(TABLE_ENTRIES - 1)) + TABLE_ENTRIES;
    endfunction

    // chain displacements until a free slot or the kick limit
    function bit place(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      int a, b, s, kicks;
      logic [KEY_W-1:0] ok;
      logic [VAL_W-1:0] ov;
      kicks = 0;
      forever begin
        if (kicks > MAX_KICKS) return 1'b0;
        a = slot_a(k);
        b = slot_b(k);
        if (keys[a] == EMPTY_KEY) begin
          keys[a] = k; vals[a] = v; return 1'b1;
        end
        if (keys[b] == EMPTY_KEY) begin
          keys[b] = k; vals[b] = v; return 1'b1;
        end
        s = (next_random() & 1) == 0 ? a : b;
        ok = keys[s]; ov = vals[s];
        keys[s] = k; vals[s] = v;
        k = ok; v = ov;
        kicks++;
      end
    endfunction

    function void write_reg(logic idx, logic [MULT_W-1:0] d);
      if (idx == CFG_MULT_ONE) mult_one = d;
      else mult_two = d;
    endfunction

    function void note_request(ckh_in_t req);
      ckh_out_t r;
      int a, b;
      r.status = ST_OK;
      r.found_value = '0;
      case (req.operation)
        OP_LOOKUP: begin
          r.status = ST_MISS;
          if (req.key != EMPTY_KEY) begin
            a = slot_a(req.key);
            b = slot_b(req.key);
            if (keys[a] == req.key) begin
              r.status = ST_OK; r.found_value = vals[a];
            end else if (keys[b] == req.key) begin
              r.status = ST_OK; r.found_value = vals[b];
            end
          end
        end
        OP_INSERT: begin
          if (req.key != EMPTY_KEY && !place(req.key, req.value)) r.status = ST_FAIL;
        end
        OP_REMOVE: begin
          if (req.key != EMPTY_KEY) begin
            a = slot_a(req.key);
            b = slot_b(req.key);
            if (keys[a] == req.key) keys[a] = EMPTY_KEY;
            if (keys[b] == req.key) keys[b] = EMPTY_KEY;
          end
        end
        default: begin
          for (int i = 0; i < STORE_DEPTH; i++) keys[i] = EMPTY_KEY;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(ckh_out_t got);
      ckh_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d value=%h", $realtime, got.status,
                 got.found_value);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, want.status, got.status);
        errors++;
      end
      if (got.found_value !== want.found_value) begin
        $display("%0t: value expected %h actual %h", $realtime, want.found_value,
                 got.found_value);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  ckh_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ckh_out_t          out_data;
  logic              cfg_we = 1'b0;
  logic              cfg_index = 1'b0;
  logic [MULT_W-1:0] cfg_data = '0;

  map_scoreboard board = new();
  int  send_idle = 0;      // percent of cycles the sender idles
  int  recv_stall = 0;     // percent of cycles the receiver stalls
  bit  hold_off = 1'b0;    // long receiver hold-off in progress
  longint cycles = 0;
  logic [KEY_W-1:0] key_pool [64];

  cuckoo_hash_map uut (.*);

  always #1 clk = ~clk;

  // Bound the run; slow inserts and 8192-entry clears are covered many times
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd40_000_000) begin
      $display("[cuckoo_hash_map] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
  end

  // Write one register, then wait with cfg_we low so back-to-back writes stay apart
  task automatic write_cfg(logic idx, logic [MULT_W-1:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, d);
    @(posedge clk);
  endtask

  // Offer one request and hold it until transferred; valid stays up until
  // the next request or idle cycle replaces it
  task automatic send(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    ckh_in_t req;
    req.operation = op; req.key = k; req.value = v;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'({$urandom, $urandom});
  endfunction

  task automatic random_phase(int n, int pool);
    int r;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      k = ($urandom_range(9) == 0) ? rand_key() : key_pool[$urandom_range(pool - 1)];
      if (r < 45) send(OP_INSERT, k, $urandom);
      else if (r < 80) send(OP_LOOKUP, k, $urandom);
      else if (r < 99) send(OP_REMOVE, k, $urandom);
      else send(OP_CLEAR, k, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 64; i++) key_pool[i] = rand_key();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, marker key, every operation
    send(OP_LOOKUP, '0, '0);
    send(OP_INSERT, '0, '1);
    send(OP_LOOKUP, '0, '0);
    send(OP_INSERT, EMPTY_KEY - 1, 32'h0000_0001);
    send(OP_LOOKUP, EMPTY_KEY - 1, '1);
    send(OP_INSERT, EMPTY_KEY, 32'hdead_beef);
    send(OP_LOOKUP, EMPTY_KEY, '0);
    send(OP_REMOVE, EMPTY_KEY, '0);
    send(OP_REMOVE, '0, '0);
    send(OP_LOOKUP, '0, '0);
    send(OP_LOOKUP, EMPTY_KEY - 1, '0);
    send(OP_CLEAR, '0, '0);
    send(OP_LOOKUP, EMPTY_KEY - 1, '0);
    drain();

    // Kick limit: zero multipliers put every key in the same two slots
    write_cfg(CFG_MULT_ONE, '0);
    write_cfg(CFG_MULT_TWO, '0);
    send(OP_INSERT, 63'd5, 32'd50);
    send(OP_INSERT, 63'd6, 32'd60);
    send(OP_INSERT, 63'd7, 32'd70);
    send(OP_LOOKUP, 63'd5, '0);
    send(OP_LOOKUP, 63'd6, '0);
    send(OP_LOOKUP, 63'd7, '0);
    send(OP_CLEAR, '0, '0);
    drain();

    // Multipliers of all ones and one, random traffic with no idling
    write_cfg(CFG_MULT_ONE, '1);
    write_cfg(CFG_MULT_TWO, 64'd1);
    send_idle = 0; recv_stall = 0;
    random_phase(200, 64);
    drain();

    // Reset values of the multipliers, sender then receiver idling phases
    write_cfg(CFG_MULT_ONE, MULT_ONE_RST);
    write_cfg(CFG_MULT_TWO, MULT_TWO_RST);
    send_idle = 63; recv_stall = 0;
    random_phase(300, 64);
    send_idle = 0; recv_stall = 63;
    random_phase(300, 64);
    drain();

    // Random multipliers; long hold-off fills the result path
    write_cfg(CFG_MULT_ONE, {$urandom, $urandom});
    write_cfg(CFG_MULT_TWO, {$urandom, $urandom});
    send_idle = 20; recv_stall = 20;
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(300, 64);
    join
    send_idle = 0; recv_stall = 0;
    random_phase(300, 64);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[cuckoo_hash_map] OK");
    end else begin
      $display("[cuckoo_hash_map] ERROR");
    end
    $finish;
  end
endmodule
